// ----- sv/mte_pkg.sv -----
package mte_pkg;

	// Longest run one text byte can cause: a space and a six-symbol code.
	localparam int MaxSyms = 7;
	localparam int CntW = $clog2(MaxSyms + 1);
	localparam int FifoDepthDef = 2;

	typedef enum logic [1:0] {
		SYM_DOT   = 2'd0,
		SYM_DASH  = 2'd1,
		SYM_SPACE = 2'd2,
		SYM_SLASH = 2'd3
	} sym_t;

	// One Morse code: dashes is left justified, first symbol in bit 5, 1 = dash.
	typedef struct packed {
		logic       ok;
		logic [2:0] len;
		logic [5:0] dashes;
	} code_t;

	// Work handed from classifier to symbol sequencer; seq[0] goes out first.
	typedef struct packed {
		sym_t [MaxSyms-1:0] seq;
		logic [CntW-1:0]    cnt;
		logic               bad;
	} cmd_t;

	localparam logic [7:0] ChLowA = 8'h61;
	localparam logic [7:0] ChLowZ = 8'h7A;
	localparam logic [7:0] CaseOffset = 8'h20;

	function automatic logic is_space(input logic [7:0] c);
		is_space = (c >= 8'h09 && c <= 8'h0D) || c == 8'h20;
	endfunction

	function automatic code_t find_code(input logic [7:0] c_raw);
		logic [7:0] c;
		code_t r;
		c = (c_raw >= ChLowA && c_raw <= ChLowZ) ? c_raw - CaseOffset : c_raw;
		r = '{ok: 1'b1, len: 3'd0, dashes: 6'b000000};
		unique case (c)
			8'h41: r = '{1'b1, 3'd2, 6'b010000}; // A
			8'h42: r = '{1'b1, 3'd4, 6'b100000}; // B
			8'h43: r = '{1'b1, 3'd4, 6'b101000}; // C
			8'h44: r = '{1'b1, 3'd3, 6'b100000}; // D
			8'h45: r = '{1'b1, 3'd1, 6'b000000}; // E
			8'h46: r = '{1'b1, 3'd4, 6'b001000}; // F
			8'h47: r = '{1'b1, 3'd3, 6'b110000}; // G
			8'h48: r = '{1'b1, 3'd4, 6'b000000}; // H
			8'h49: r = '{1'b1, 3'd2, 6'b000000}; // I
			8'h4A: r = '{1'b1, 3'd4, 6'b011100}; // J
			8'h4B: r = '{1'b1, 3'd3, 6'b101000}; // K
			8'h4C: r = '{1'b1, 3'd4, 6'b010000}; // L
			8'h4D: r = '{1'b1, 3'd2, 6'b110000}; // M
			8'h4E: r = '{1'b1, 3'd2, 6'b100000}; // N
			8'h4F: r = '{1'b1, 3'd3, 6'b111000}; // O
			8'h50: r = '{1'b1, 3'd4, 6'b011000}; // P
			8'h51: r = '{1'b1, 3'd4, 6'b110100}; // Q
			8'h52: r = '{1'b1, 3'd3, 6'b010000}; // R
			8'h53: r = '{1'b1, 3'd3, 6'b000000}; // S
			8'h54: r = '{1'b1, 3'd1, 6'b100000}; // T
			8'h55: r = '{1'b1, 3'd3, 6'b001000}; // U
			8'h56: r = '{1'b1, 3'd4, 6'b000100}; // V
			8'h57: r = '{1'b1, 3'd3, 6'b011000}; // W
			8'h58: r = '{1'b1, 3'd4, 6'b100100}; // X
			8'h59: r = '{1'b1, 3'd4, 6'b101100}; // Y
			8'h5A: r = '{1'b1, 3'd4, 6'b110000}; // Z
			8'h30: r = '{1'b1, 3'd5, 6'b111110}; // 0
			8'h31: r = '{1'b1, 3'd5, 6'b011110}; // 1
			8'h32: r = '{1'b1, 3'd5, 6'b001110}; // 2
			8'h33: r = '{1'b1, 3'd5, 6'b000110}; // 3
			8'h34: r = '{1'b1, 3'd5, 6'b000010}; // 4
			8'h35: r = '{1'b1, 3'd5, 6'b000000}; // 5
			8'h36: r = '{1'b1, 3'd5, 6'b100000}; // 6
			8'h37: r = '{1'b1, 3'd5, 6'b110000}; // 7
			8'h38: r = '{1'b1, 3'd5, 6'b111000}; // 8
			8'h39: r = '{1'b1, 3'd5, 6'b111100}; // 9
			8'h2E: r = '{1'b1, 3'd6, 6'b010101}; // .
			8'h2C: r = '{1'b1, 3'd6, 6'b110011}; // ,
			8'h3F: r = '{1'b1, 3'd6, 6'b001100}; // ?
			8'h21: r = '{1'b1, 3'd6, 6'b101011}; // !
			8'h2D: r = '{1'b1, 3'd6, 6'b100001}; // -
			8'h3A: r = '{1'b1, 3'd6, 6'b111000}; // :
			8'h2F: r = '{1'b1, 3'd5, 6'b100100}; // /
			default: r = '{1'b0, 3'd0, 6'b000000};
		endcase
		return r;
	endfunction

endpackage

// ----- sv/mte_ifs.sv -----
interface mte_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_text;

	modport source (output valid, output char_code, output end_of_text, input ready);
	modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

interface mte_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] symbol;
	logic       unsupported;
	logic       last_of_run;

	modport source (output valid, output symbol, output unsupported, output last_of_run,
		input ready);
	modport sink (input valid, input symbol, input unsupported, input last_of_run,
		output ready);
endinterface

// ----- sv/mte_front.sv -----
module mte_front (
	input  logic          clk,
	input  logic          arst_n,
	mte_in_if.sink        in_ch,
	output logic          push_valid,
	input  logic          push_ready,
	output mte_pkg::cmd_t push_cmd
);
	import mte_pkg::*;

	logic  at_start_q;
	logic  after_sep_q;
	logic  error_q;
	logic  accept;
	logic  ws;
	logic  pre;
	code_t code;
	sym_t [MaxSyms-1:0] pat;

	assign ws   = is_space(in_ch.char_code);
	assign code = find_code(in_ch.char_code);
	assign pre  = !at_start_q && !after_sep_q;

	assign in_ch.ready = push_ready;
	assign accept      = in_ch.valid && in_ch.ready;

	// Dot/dash slots of the looked-up code, first symbol in slot 0.
	always_comb begin
		for (int k = 0; k < 6; k++) begin
			pat[k] = code.dashes[5-k] ? SYM_DASH : SYM_DOT;
		end
		pat[MaxSyms-1] = SYM_DOT;
	end

	always_comb begin
		push_cmd.seq = '{default: SYM_DOT};
		push_cmd.cnt = '0;
		push_cmd.bad = 1'b0;
		push_valid   = 1'b0;
		if (!error_q) begin
			if (ws) begin
				push_valid      = in_ch.valid && pre;
				push_cmd.seq[0] = SYM_SPACE;
				push_cmd.seq[1] = SYM_SLASH;
				push_cmd.seq[2] = SYM_SPACE;
				push_cmd.cnt    = CntW'(3);
			end else if (!code.ok) begin
				push_valid   = in_ch.valid;
				push_cmd.bad = 1'b1;
				push_cmd.cnt = CntW'(1);
			end else begin
				push_valid   = in_ch.valid;
				push_cmd.cnt = CntW'(code.len) + CntW'(pre);
				if (pre) begin
					push_cmd.seq[0] = SYM_SPACE;
					for (int k = 1; k < MaxSyms; k++) begin
						push_cmd.seq[k] = pat[k-1];
					end
				end else begin
					push_cmd.seq = pat;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q  <= 1'b1;
			after_sep_q <= 1'b0;
			error_q     <= 1'b0;
		end else if (accept) begin
			if (in_ch.end_of_text) begin
				at_start_q  <= 1'b1;
				after_sep_q <= 1'b0;
				error_q     <= 1'b0;
			end else if (!error_q) begin
				if (ws) begin
					if (pre) after_sep_q <= 1'b1;
				end else if (!code.ok) begin
					error_q <= 1'b1;
				end else begin
					at_start_q  <= 1'b0;
					after_sep_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ----- sv/mte_cmd_fifo.sv -----
// DEPTH: power of two, at least 2.
module mte_cmd_fifo #(
	parameter int DEPTH = mte_pkg::FifoDepthDef
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  mte_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output mte_pkg::cmd_t pop_cmd
);
	import mte_pkg::*;

	localparam int PtrW = $clog2(DEPTH);
	localparam int CntFW = $clog2(DEPTH + 1);

	cmd_t            mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntFW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = count_q != CntFW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + PtrW'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CntFW'(1);
				2'b01:   count_q <= count_q - CntFW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- sv/mte_back.sv -----
module mte_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  mte_pkg::cmd_t pop_cmd,
	mte_out_if.source     out_ch
);
	import mte_pkg::*;

	logic               busy_q;
	sym_t [MaxSyms-1:0] seq_q;
	sym_t [MaxSyms-1:0] seq_shift;
	logic [CntW-1:0]    cnt_q;
	logic               bad_q;
	logic               out_valid_q;
	sym_t               symbol_q;
	logic               bad_out_q;
	logic               last_q;
	logic               advance;
	logic               final_sym;
	logic               load;

	assign advance   = !out_valid_q || out_ch.ready;
	assign final_sym = cnt_q == CntW'(1);
	assign pop_ready = !busy_q || (advance && final_sym);
	assign load      = pop_valid && pop_ready;

	always_comb begin
		for (int k = 0; k < MaxSyms - 1; k++) begin
			seq_shift[k] = seq_q[k+1];
		end
		seq_shift[MaxSyms-1] = SYM_DOT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) out_valid_q <= busy_q;
			// a new run replaces the one whose last symbol goes out this cycle
			if (load) begin
				busy_q <= 1'b1;
				cnt_q  <= pop_cmd.cnt;
			end else if (advance && busy_q) begin
				cnt_q <= cnt_q - CntW'(1);
				if (final_sym) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && busy_q) begin
			symbol_q  <= seq_q[0];
			bad_out_q <= bad_q;
			last_q    <= final_sym;
		end
		if (load) begin
			seq_q <= pop_cmd.seq;
			bad_q <= pop_cmd.bad;
		end else if (advance && busy_q) begin
			seq_q <= seq_shift;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.symbol      = symbol_q;
	assign out_ch.unsupported = bad_out_q;
	assign out_ch.last_of_run = last_q;

	a_busy_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0)
		else $error("sequencer busy with no symbols left");

	a_bad_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && bad_q |-> cnt_q == CntW'(1))
		else $error("unsupported run longer than one result");

	a_bad_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.unsupported |-> out_ch.last_of_run)
		else $error("unsupported result not marked last");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load && busy_q |-> advance && final_sym)
		else $error("new run loaded over unfinished run");

endmodule

// ----- sv/morse_text_encoder_unit.sv -----
// Morse text encoder: one text byte in, a run of Morse symbols out.
// in_ch  (valid/ready): char_code, end_of_text. An item is taken on valid && ready.
// out_ch (valid/ready): symbol (0 dot, 1 dash, 2 space, 3 slash), unsupported,
//   last_of_run. One result per cycle while the receiver is ready.
// Each byte yields 0 to 7 results: whitespace gives " / " once after a code,
// a code gives an optional leading space plus up to six dots/dashes, a byte
// with no code gives one flagged dot and mutes output until end_of_text.
// The first result of an item passes classifier -> command queue -> sequencer
// run register -> symbol sequencer output register.
// The sequencer's single output register passes one symbol per cycle while the
// receiver is ready; an item yields as many results as its run holds (7 at most,
// none for a silent byte). Runs of consecutive items go out with no gap.
// The command queue (FIFO_DEPTH entries) lets the classifier keep taking items
// while the sequencer is busy or the receiver stalls; in_ch.ready drops only
// when the queue is full. A stalled result holds on out_ch.
// Reset: queue empty, no result pending, text state back to start of text.
module morse_text_encoder_unit #(
	parameter int FIFO_DEPTH = mte_pkg::FifoDepthDef
) (
	input  logic      clk,
	input  logic      arst_n,
	mte_in_if.sink    in_ch,
	mte_out_if.source out_ch
);
	import mte_pkg::*;

	// classifier -> queue
	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;

	// queue -> sequencer
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	mte_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	mte_cmd_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	mte_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.out_ch    (out_ch)
	);

endmodule

// ----- sim/tb_morse_text_encoder_unit.sv -----
module tb_morse_text_encoder_unit;
	import mte_pkg::*;

	// Hard stop.
	localparam int CycleLimit = 200000;
	// Non-muted random text bytes to send after the opening rows.
	localparam int LiveBytesTarget = 270;
	// Cycles to watch for stray symbols once nothing is expected.
	localparam int DrainCycles = 16;

	localparam logic [7:0] ChTab = 8'h09;
	localparam logic [7:0] ChCr = 8'h0D;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] FoldOffset = 8'h20;

	// Shorthand used in the opening rows for an expected symbol run:
	// '.' dot, '-' dash, ' ' space, '/' slash, '!' flagged dot.
	localparam byte MarkDot = ".";
	localparam byte MarkDash = "-";
	localparam byte MarkSpace = " ";
	localparam byte MarkSlash = "/";
	localparam byte MarkBad = "!";

	typedef struct packed {
		sym_t symbol;
		logic unsupported;
		logic last_of_run;
	} morse_sym_t;

	// One text byte to send; when spelled is set, morse holds the run it must cause.
	typedef struct {
		logic [7:0] code;
		logic       eot;
		bit         spelled;
		string      morse;
	} text_row_t;

	logic clk;
	logic arst_n;

	mte_in_if  in_ch ();
	mte_out_if out_ch ();

	morse_text_encoder_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Encoder model: text state plus code tables
	// ------------------------------------------------------------------
	bit text_start;   // no code emitted yet in this text
	bit sep_last;     // last thing emitted was a word separator
	bit text_bad;     // unsupported byte seen, output muted until end of text

	string letter_codes [26] = '{
		".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
		"-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
		"..-", "...-", ".--", "-..-", "-.--", "--.."
	};
	string digit_codes [10] = '{
		"-----", ".----", "..---", "...--", "....-",
		".....", "-....", "--...", "---..", "----."
	};
	string coded_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,?!-:/";

	morse_sym_t byte_run[$];       // symbols caused by the byte just taken
	morse_sym_t pending_morse[$];  // symbols still owed by the block

	function automatic bit is_blank(input logic [7:0] c);
		return (c >= ChTab && c <= ChCr) || c == ChSpace;
	endfunction

	// Empty string means the byte has no Morse code.
	function automatic string code_for(input logic [7:0] c_raw);
		logic [7:0] c;
		c = (c_raw >= "a" && c_raw <= "z") ? c_raw - FoldOffset : c_raw;
		if (c >= "A" && c <= "Z")
			return letter_codes[c - "A"];
		if (c >= "0" && c <= "9")
			return digit_codes[c - "0"];
		case (c)
			".": return ".-.-.-";
			",": return "--..--";
			"?": return "..--..";
			"!": return "-.-.--";
			"-": return "-....-";
			":": return "---...";
			"/": return "-..-.";
			default: return "";
		endcase
	endfunction

	function automatic void add_sym(input sym_t s, input logic bad);
		byte_run.push_back('{s, bad, 1'b0});
	endfunction

	function automatic void close_run();
		if (byte_run.size() > 0)
			byte_run[byte_run.size() - 1].last_of_run = 1'b1;
	endfunction

	// Advance the text state by one byte and leave its symbols in byte_run.
	function automatic void encode_byte(input logic [7:0] c, input logic eot);
		string code;
		byte_run.delete();
		if (!text_bad) begin
			if (is_blank(c)) begin
				// separator only between words, never doubled
				if (!text_start && !sep_last) begin
					add_sym(SYM_SPACE, 1'b0);
					add_sym(SYM_SLASH, 1'b0);
					add_sym(SYM_SPACE, 1'b0);
					sep_last = 1'b1;
				end
			end else begin
				code = code_for(c);
				if (code.len() == 0) begin
					add_sym(SYM_DOT, 1'b1);
					text_bad = 1'b1;
				end else begin
					if (!text_start && !sep_last)
						add_sym(SYM_SPACE, 1'b0);
					for (int i = 0; i < code.len(); i++)
						add_sym(code[i] == MarkDash ? SYM_DASH : SYM_DOT, 1'b0);
					text_start = 1'b0;
					sep_last = 1'b0;
				end
			end
		end
		close_run();
		if (eot) begin
			text_start = 1'b1;
			sep_last = 1'b0;
			text_bad = 1'b0;
		end
	endfunction

	// Replace byte_run with a run written out by hand.
	function automatic void spell_run(input string s);
		byte_run.delete();
		for (int i = 0; i < s.len(); i++) begin
			case (s[i])
				MarkDot:   add_sym(SYM_DOT, 1'b0);
				MarkDash:  add_sym(SYM_DASH, 1'b0);
				MarkSpace: add_sym(SYM_SPACE, 1'b0);
				MarkSlash: add_sym(SYM_SLASH, 1'b0);
				MarkBad:   add_sym(SYM_DOT, 1'b1);
				default:   add_sym(SYM_DOT, 1'b0);
			endcase
		end
		close_run();
	endfunction

	// ------------------------------------------------------------------
	// Opening rows: extremes, every class of byte, the state corners
	// ------------------------------------------------------------------
	text_row_t opening_rows [25] = '{
		'{"E",   1'b0, 1'b1, "."},          // first code after reset, no space
		'{" ",   1'b0, 1'b1, " / "},        // word separator
		'{ChTab, 1'b0, 1'b1, ""},           // no second separator
		'{"a",   1'b0, 1'b1, ".-"},         // lower case, no space after separator
		'{"z",   1'b0, 1'b1, " --.."},      // top of lower case
		'{"0",   1'b0, 1'b1, " -----"},
		'{"9",   1'b0, 1'b0, ""},
		'{".",   1'b0, 1'b1, " .-.-.-"},    // longest run: space plus six
		'{",",   1'b0, 1'b0, ""},
		'{"!",   1'b0, 1'b0, ""},
		'{"-",   1'b0, 1'b0, ""},
		'{"/",   1'b0, 1'b0, ""},
		'{ChCr,  1'b0, 1'b1, " / "},        // top of the whitespace range
		'{8'h0A, 1'b1, 1'b1, ""},           // end of text right after separator
		'{" ",   1'b0, 1'b1, ""},           // blank at start of text: silent
		'{8'h0B, 1'b0, 1'b1, ""},
		'{"Z",   1'b0, 1'b1, "--.."},       // leading blanks leave text at start
		'{8'h00, 1'b0, 1'b1, "!"},          // lowest byte has no code
		'{"A",   1'b0, 1'b1, ""},           // muted after the error
		'{ChSpace, 1'b1, 1'b1, ""},         // muted end of text clears the error
		'{8'hFF, 1'b0, 1'b1, "!"},          // highest byte has no code
		'{"M",   1'b1, 1'b1, ""},           // muted, closes the text
		'{"T",   1'b0, 1'b1, "-"},
		'{8'h60, 1'b0, 1'b1, "!"},          // just below 'a', flagged without space
		'{8'h0C, 1'b1, 1'b1, ""}
	};

	text_row_t text_q[$];   // bytes still to send
	text_row_t drv_item;    // byte on in_ch right now

	int  n_sent;
	int  n_syms;
	int  n_flagged;
	int  n_texts;
	int  errors;
	int  cycles;

	// ------------------------------------------------------------------
	// Timeout
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("%0t: timeout after %0d cycles, %0d symbols still owed",
				$time, cycles, pending_morse.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Scoreboard: outputs are checked before the item taken on the same
	// edge is modeled; its symbols reach out_ch only after the queue and sequencer.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		morse_sym_t got;
		morse_sym_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got = '{sym_t'(out_ch.symbol), out_ch.unsupported, out_ch.last_of_run};
				if (pending_morse.size() == 0) begin
					errors++;
					$display("%0t: symbol with nothing expected: %s",
						$time, "");
					$display("  got sym=%0d unsupported=%0b last=%0b",
						got.symbol, got.unsupported, got.last_of_run);
				end else begin
					want = pending_morse.pop_front();
					n_syms++;
					if (got.unsupported)
						n_flagged++;
					if (got !== want) begin
						errors++;
						$display("%0t: mismatch: expected sym=%0d unsupported=%0b last=%0b,",
							$time, want.symbol, want.unsupported, want.last_of_run);
						$display("  got sym=%0d unsupported=%0b last=%0b",
							got.symbol, got.unsupported, got.last_of_run);
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				encode_byte(drv_item.code, drv_item.eot);
				// hand-written rows override the model's run, the state still advances
				if (drv_item.spelled)
					spell_run(drv_item.morse);
				foreach (byte_run[i])
					pending_morse.push_back(byte_run[i]);
				if (drv_item.eot)
					n_texts++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: rotating ready pattern, picked anew at random intervals.
	// All-ones gives stall-free stretches; 8'h81 holds ready low for most of each rotation.
	// ------------------------------------------------------------------
	initial begin
		logic [7:0] ready_pat;
		int         hold;
		out_ch.ready = 1'b0;
		ready_pat = 8'hFF;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold == 0) begin
				hold = $urandom_range(16, 80);
				case ($urandom_range(0, 3))
					0: ready_pat = 8'hFF;
					1: ready_pat = 8'($urandom) | 8'h01;
					2: ready_pat = 8'h81;
					default: ready_pat = 8'b1010_1100;
				endcase
			end
			hold--;
			out_ch.ready = ready_pat[0];
			ready_pat = {ready_pat[0], ready_pat[7:1]};
		end
	end

	// ------------------------------------------------------------------
	// Sender: builds the byte list, then drives it in bursts
	// ------------------------------------------------------------------
	initial begin
		text_row_t  row;
		logic [7:0] ch;
		string      code;
		int         live;
		int         len;
		int         pick;
		int         burst;
		int         gap;
		bit         dead;

		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.char_code = '0;
		in_ch.end_of_text = 1'b0;
		text_start = 1'b1;
		sep_last = 1'b0;
		text_bad = 1'b0;
		n_sent = 0;
		n_syms = 0;
		n_flagged = 0;
		n_texts = 0;
		errors = 0;
		cycles = 0;

		foreach (opening_rows[i])
			text_q.push_back(opening_rows[i]);

		// Random texts: mostly coded characters and whitespace, a little
		// noise. Bytes after an error in the same text only count as filler.
		live = 0;
		while (live < LiveBytesTarget) begin
			len = $urandom_range(1, 24);
			dead = 1'b0;
			for (int k = 0; k < len; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					ch = coded_chars[$urandom_range(0, coded_chars.len() - 1)];
					if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1) == 1)
						ch = ch + FoldOffset;
				end else if (pick < 97) begin
					pick = $urandom_range(0, 5);
					ch = (pick == 5) ? ChSpace : ChTab + 8'(pick);
				end else begin
					ch = 8'($urandom_range(0, 255));
				end
				if (!dead) begin
					live++;
					code = code_for(ch);
					if (!is_blank(ch) && code.len() == 0)
						dead = 1'b1;
				end
				text_q.push_back('{ch, (k == len - 1), 1'b0, ""});
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		burst = 0;
		while (text_q.size() > 0) begin
			row = text_q.pop_front();
			if (burst == 0) begin
				burst = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
				if (gap > 0) begin
					in_ch.valid = 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			burst--;
			drv_item = row;
			in_ch.char_code = row.code;
			in_ch.end_of_text = row.eot;
			in_ch.valid = 1'b1;
			do
				@(posedge clk);
			while (!in_ch.ready);
			@(negedge clk);
			n_sent++;
		end
		in_ch.valid = 1'b0;

		// Silent bytes leave no trace in the queue, so watch a while longer.
		while (pending_morse.size() > 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("Sent %0d text bytes in %0d texts; checked %0d Morse symbols",
			n_sent, n_texts, n_syms);
		$display("  of which %0d flagged unsupported, %0d mismatches", n_flagged, errors);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
sv/mte_pkg.sv
sv/mte_ifs.sv
sv/mte_front.sv
sv/mte_cmd_fifo.sv
sv/mte_back.sv
sv/morse_text_encoder_unit.sv
sim/tb_morse_text_encoder_unit.sv
